FILE: design/two_finger_gesture_extractor_unit_assert.svh
// Assertion macros shared by the gesture extractor modules.
`ifndef TWO_FINGER_GESTURE_EXTRACTOR_UNIT_ASSERT_SVH
`define TWO_FINGER_GESTURE_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TFG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TFG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tfg_pkg.sv
`default_nettype none
package tfg_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ROOT_STEPS = 18;          // result bits of the square root
   localparam int DIV_BITS   = 26;          // quotient bits of the scale divide
   // step counter covers the divide, the longest loop (CORDIC_STEPS is at most 24)
   localparam int STEP_W     = $clog2(DIV_BITS);
   localparam logic signed [23:0] PI_Q20 = 24'sd3294199;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_RSQ, ST_RND,
      ST_ANG_INIT, ST_ANG_STEP, ST_DIV_INIT, ST_DIV_STEP, ST_DONE
   } tfg_state_type;

   typedef struct packed {
      logic              capture;
      logic              load;
      logic              sq_x;
      logic              sq_y;
      logic              root;
      logic              rsq;
      logic              rnd;
      logic              ang_init;
      logic              ang_step;
      logic              div_init;
      logic              div_step;
      logic              commit;
      logic              sel_old;
      logic [STEP_W-1:0] step;
   } tfg_cmd_type;

   typedef struct packed {
      logic touch;
      logic cond;
      logic out_free;
   } tfg_sts_type;

   function automatic logic [19:0] atan_q20(input logic [4:0] i);
      logic [19:0] v;
      case (i)
         5'd0:  v = 20'd823550;
         5'd1:  v = 20'd486170;
         5'd2:  v = 20'd256879;
         5'd3:  v = 20'd130396;
         5'd4:  v = 20'd65451;
         5'd5:  v = 20'd32757;
         5'd6:  v = 20'd16383;
         5'd7:  v = 20'd8192;
         5'd8:  v = 20'd4096;
         5'd9:  v = 20'd2048;
         5'd10: v = 20'd1024;
         5'd11: v = 20'd512;
         5'd12: v = 20'd256;
         5'd13: v = 20'd128;
         5'd14: v = 20'd64;
         5'd15: v = 20'd32;
         5'd16: v = 20'd16;
         5'd17: v = 20'd8;
         5'd18: v = 20'd4;
         5'd19: v = 20'd2;
         5'd20: v = 20'd1;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: design/tfg_ctrl.sv
`default_nettype none
module tfg_ctrl #(
   parameter int CORDIC_STEPS = tfg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire tfg_pkg::tfg_sts_type sts,
   output tfg_pkg::tfg_cmd_type     cmd
);
   import tfg_pkg::*;

   tfg_state_type     state_ff, state_in;
   logic              sel_ff, sel_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_root, last_ang, last_div;

   assign last_root = (step_ff == STEP_W'(ROOT_STEPS - 1));
   assign last_ang  = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign last_div  = (step_ff == STEP_W'(DIV_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      step_in  = '0;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_LOAD;
         ST_LOAD: begin
            sel_in = 1'b0;
            if (sts.touch && sts.cond) state_in = ST_SQ_X;
            else state_in = ST_DONE;
         end
         ST_SQ_X:     state_in = ST_SQ_Y;
         ST_SQ_Y:     state_in = ST_ROOT;
         ST_ROOT: begin
            step_in = step_ff + 1'b1;
            if (last_root) begin
               step_in  = '0;
               state_in = ST_RSQ;
            end
         end
         ST_RSQ:      state_in = ST_RND;
         ST_RND: begin
            if (sel_ff) state_in = ST_ANG_INIT;
            else begin
               sel_in   = 1'b1;
               state_in = ST_SQ_X;
            end
         end
         ST_ANG_INIT: state_in = ST_ANG_STEP;
         ST_ANG_STEP: begin
            step_in = step_ff + 1'b1;
            if (last_ang) begin
               step_in  = '0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: begin
            step_in = step_ff + 1'b1;
            if (last_div) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE:     if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.sel_old = sel_ff;
      cmd.step    = step_ff;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            // hold off the sender while reset is applied
            req_stall   = reset;
            cmd.capture = req_valid && !reset;
         end
         ST_LOAD:     cmd.load     = 1'b1;
         ST_SQ_X:     cmd.sq_x     = 1'b1;
         ST_SQ_Y:     cmd.sq_y     = 1'b1;
         ST_ROOT:     cmd.root     = 1'b1;
         ST_RSQ:      cmd.rsq      = 1'b1;
         ST_RND:      cmd.rnd      = 1'b1;
         ST_ANG_INIT: cmd.ang_init = 1'b1;
         ST_ANG_STEP: cmd.ang_step = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV_STEP: cmd.div_step = 1'b1;
         ST_DONE:     cmd.commit   = sts.out_free;
         default:     cmd.commit   = 1'b0;
      endcase
   end

`include "two_finger_gesture_extractor_unit_assert.svh"
   `TFG_ASSERT_NEXT(a_done_hold, state_ff == ST_DONE && !sts.out_free, state_ff == ST_DONE, "result dropped while output busy")
   `TFG_ASSERT_NEXT(a_skip_measure, state_ff == ST_LOAD && !sts.touch, state_ff == ST_DONE, "non-touch event entered measurement")
   `TFG_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "commit while output register full")

endmodule
`default_nettype wire

FILE: design/tfg_dp.sv
`default_nettype none
module tfg_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tfg_pkg::tfg_cmd_type cmd,
   output tfg_pkg::tfg_sts_type     sts,
   input  wire logic                req_is_touch,
   input  wire logic                req_begin_req,
   input  wire logic [3:0]          req_point_count,
   input  wire logic [7:0]          req_id_a,
   input  wire logic                req_ended_a,
   input  wire logic signed [15:0]  req_x_a,
   input  wire logic signed [15:0]  req_y_a,
   input  wire logic [7:0]          req_id_b,
   input  wire logic                req_ended_b,
   input  wire logic signed [15:0]  req_x_b,
   input  wire logic signed [15:0]  req_y_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_gesture_valid,
   output logic signed [16:0]       rsp_pan_x,
   output logic signed [16:0]       rsp_pan_y,
   output logic [16:0]              rsp_new_distance,
   output logic [16:0]              rsp_old_distance,
   output logic signed [17:0]       rsp_pinch_pixels,
   output logic signed [15:0]       rsp_mid_x,
   output logic signed [15:0]       rsp_mid_y,
   output logic [15:0]              rsp_scale,
   output logic signed [15:0]       rsp_twist
);
   import tfg_pkg::*;

   // captured event
   logic              touch_ff, begin_ff, ea_ff, eb_ff;
   logic [3:0]        cnt_ff;
   logic [7:0]        ida_ff, idb_ff;
   logic signed [15:0] xa_ff, ya_ff, xb_ff, yb_ff;
   // previous pair
   logic              pp_ff, pea_ff, peb_ff;
   logic [7:0]        pida_ff, pidb_ff;
   logic signed [15:0] pxa_ff, pya_ff, pxb_ff, pyb_ff;
   // work registers
   logic              cond_ff;
   logic signed [16:0] nvx_ff, nvy_ff, ovx_ff, ovy_ff, panx_ff, pany_ff;
   logic signed [15:0] midx_ff, midy_ff;
   logic [33:0]       s_ff;
   logic [17:0]       root_ff;
   logic [35:0]       rr_ff;
   logic [16:0]       nd_ff, od_ff;
   logic signed [29:0] cx_ff [2];
   logic signed [29:0] cy_ff [2];
   logic signed [23:0] cz_ff [2];
   logic              zf_ff [2];
   logic [DIV_BITS-1:0] num_ff;
   logic [17:0]       rem_ff;
   // held result
   logic              rv_ff, hv_ff;
   logic signed [16:0] hpx_ff, hpy_ff;
   logic [16:0]       hnd_ff, hod_ff;
   logic signed [17:0] hpinch_ff;
   logic signed [15:0] hmx_ff, hmy_ff, htw_ff;
   logic [15:0]       hsc_ff;

   logic              cond;
   logic signed [16:0] vx, vy, vsq;
   logic signed [33:0] sq;
   logic [17:0]       tcand, root_inc;
   logic [35:0]       tt, rdiff;
   logic signed [16:0] evx [2];
   logic signed [16:0] evy [2];
   logic signed [17:0] dxa, dxb, dya, dyb;
   logic [17:0]       remsh;
   logic              ge;
   logic signed [24:0] zdiff, zrnd;
   logic signed [16:0] tw17;
   logic [15:0]       tw_sat, sc_sat;
   logic signed [23:0] zn, zo;
   logic [4:0]        aidx;

   assign cond = (cnt_ff >= 4'd2) && !begin_ff && pp_ff && (pida_ff == ida_ff) &&
                 (pidb_ff == idb_ff) && !ea_ff && !eb_ff && !pea_ff && !peb_ff;

   assign sts.touch    = touch_ff;
   assign sts.cond     = cond;
   assign sts.out_free = !rv_ff || !rsp_stall;

   assign dxa = 18'(xa_ff) - 18'(pxa_ff);
   assign dxb = 18'(xb_ff) - 18'(pxb_ff);
   assign dya = 18'(ya_ff) - 18'(pya_ff);
   assign dyb = 18'(yb_ff) - 18'(pyb_ff);

   assign vx  = cmd.sel_old ? ovx_ff : nvx_ff;
   assign vy  = cmd.sel_old ? ovy_ff : nvy_ff;
   assign vsq = cmd.sq_y ? vy : vx;
   assign sq  = vsq * vsq;

   assign tcand    = root_ff | (18'd1 << (5'(ROOT_STEPS - 1) - 5'(cmd.step)));
   assign tt       = tcand * tcand;
   assign rdiff    = {2'b00, s_ff} - rr_ff;
   assign root_inc = (rdiff > {18'd0, root_ff}) ? root_ff + 18'd1 : root_ff;

   assign evx[0] = nvx_ff;
   assign evy[0] = nvy_ff;
   assign evx[1] = ovx_ff;
   assign evy[1] = ovy_ff;
   assign aidx   = 5'(cmd.step);

   assign remsh = {rem_ff[16:0], num_ff[DIV_BITS-1]};
   assign ge    = remsh >= {1'b0, od_ff};

   assign zn     = zf_ff[0] ? 24'sd0 : cz_ff[0];
   assign zo     = zf_ff[1] ? 24'sd0 : cz_ff[1];
   assign zdiff  = 25'(zn) - 25'(zo);
   assign zrnd   = zdiff + 25'sd128;
   assign tw17   = zrnd[24:8];
   assign tw_sat = (tw17[16] != tw17[15]) ? (tw17[16] ? 16'h8000 : 16'h7FFF) : tw17[15:0];
   assign sc_sat = (od_ff == 17'd0) ? 16'd256 :
                   ((|num_ff[DIV_BITS-1:16]) ? 16'hFFFF : num_ff[15:0]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         touch_ff <= req_is_touch;
         begin_ff <= req_begin_req;
         cnt_ff   <= req_point_count;
         ida_ff   <= req_id_a;
         ea_ff    <= req_ended_a;
         xa_ff    <= req_x_a;
         ya_ff    <= req_y_a;
         idb_ff   <= req_id_b;
         eb_ff    <= req_ended_b;
         xb_ff    <= req_x_b;
         yb_ff    <= req_y_b;
      end
      if (cmd.load) begin
         cond_ff <= cond;
         nvx_ff  <= 17'(xb_ff) - 17'(xa_ff);
         nvy_ff  <= 17'(yb_ff) - 17'(ya_ff);
         ovx_ff  <= 17'(pxb_ff) - 17'(pxa_ff);
         ovy_ff  <= 17'(pyb_ff) - 17'(pya_ff);
         panx_ff <= 17'((dxa + dxb) >>> 1);
         pany_ff <= 17'((dya + dyb) >>> 1);
         midx_ff <= 16'((17'(xa_ff) + 17'(xb_ff)) >>> 1);
         midy_ff <= 16'((17'(ya_ff) + 17'(yb_ff)) >>> 1);
      end
      if (cmd.sq_x) begin
         s_ff    <= 34'(sq);
         root_ff <= '0;
      end
      if (cmd.sq_y) s_ff <= s_ff + 34'(sq);
      if (cmd.root && (tt <= {2'b00, s_ff})) root_ff <= tcand;
      if (cmd.rsq) rr_ff <= root_ff * root_ff;
      if (cmd.rnd) begin
         if (cmd.sel_old) od_ff <= root_inc[16:0];
         else nd_ff <= root_inc[16:0];
      end
      for (int e = 0; e < 2; e++) begin
         if (cmd.ang_init) begin
            // fold the left half plane onto the right starting from zero; right-half vectors start from +-pi
            zf_ff[e] <= (evx[e] == 17'sd0) && (evy[e] == 17'sd0);
            if (evx[e] > 17'sd0) begin
               cx_ff[e] <= {{5{evx[e][16]}}, evx[e], 8'd0};
               cy_ff[e] <= {{5{evy[e][16]}}, evy[e], 8'd0};
               cz_ff[e] <= (evy[e] <= 17'sd0) ? PI_Q20 : -PI_Q20;
            end else begin
               cx_ff[e] <= -{{5{evx[e][16]}}, evx[e], 8'd0};
               cy_ff[e] <= -{{5{evy[e][16]}}, evy[e], 8'd0};
               cz_ff[e] <= '0;
            end
         end
         if (cmd.ang_step) begin
            if (!cy_ff[e][29]) begin
               cx_ff[e] <= cx_ff[e] + (cy_ff[e] >>> cmd.step);
               cy_ff[e] <= cy_ff[e] - (cx_ff[e] >>> cmd.step);
               cz_ff[e] <= cz_ff[e] + 24'(atan_q20(aidx));
            end else begin
               cx_ff[e] <= cx_ff[e] - (cy_ff[e] >>> cmd.step);
               cy_ff[e] <= cy_ff[e] + (cx_ff[e] >>> cmd.step);
               cz_ff[e] <= cz_ff[e] - 24'(atan_q20(aidx));
            end
         end
      end
      if (cmd.div_init) begin
         num_ff <= {1'b0, nd_ff, 8'd0} + DIV_BITS'(od_ff[16:1]);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? remsh - {1'b0, od_ff} : remsh;
         num_ff <= {num_ff[DIV_BITS-2:0], ge};
      end
   end

   // previous pair, held result and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff     <= 1'b0;
         pida_ff   <= '0;
         pidb_ff   <= '0;
         pea_ff    <= 1'b0;
         peb_ff    <= 1'b0;
         pxa_ff    <= '0;
         pya_ff    <= '0;
         pxb_ff    <= '0;
         pyb_ff    <= '0;
         rv_ff     <= 1'b0;
         hv_ff     <= 1'b0;
         hpx_ff    <= '0;
         hpy_ff    <= '0;
         hnd_ff    <= '0;
         hod_ff    <= '0;
         hpinch_ff <= '0;
         hmx_ff    <= '0;
         hmy_ff    <= '0;
         hsc_ff    <= '0;
         htw_ff    <= '0;
      end else begin
         if (cmd.load && touch_ff) begin
            pp_ff   <= (cnt_ff >= 4'd2);
            pida_ff <= ida_ff;
            pidb_ff <= idb_ff;
            pea_ff  <= ea_ff;
            peb_ff  <= eb_ff;
            pxa_ff  <= xa_ff;
            pya_ff  <= ya_ff;
            pxb_ff  <= xb_ff;
            pyb_ff  <= yb_ff;
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (cmd.commit) begin
            rv_ff <= 1'b1;
            // a non-touch event replays the held result as it stands
            if (touch_ff) begin
               hv_ff     <= cond_ff;
               hpx_ff    <= cond_ff ? panx_ff : '0;
               hpy_ff    <= cond_ff ? pany_ff : '0;
               hnd_ff    <= cond_ff ? nd_ff : '0;
               hod_ff    <= cond_ff ? od_ff : '0;
               hpinch_ff <= cond_ff ? ({1'b0, nd_ff} - {1'b0, od_ff}) : '0;
               hmx_ff    <= cond_ff ? midx_ff : '0;
               hmy_ff    <= cond_ff ? midy_ff : '0;
               hsc_ff    <= cond_ff ? sc_sat : '0;
               htw_ff    <= cond_ff ? tw_sat : '0;
            end
         end
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_gesture_valid = hv_ff;
   assign rsp_pan_x         = hpx_ff;
   assign rsp_pan_y         = hpy_ff;
   assign rsp_new_distance  = hnd_ff;
   assign rsp_old_distance  = hod_ff;
   assign rsp_pinch_pixels  = hpinch_ff;
   assign rsp_mid_x         = hmx_ff;
   assign rsp_mid_y         = hmy_ff;
   assign rsp_scale         = hsc_ff;
   assign rsp_twist         = htw_ff;

`include "two_finger_gesture_extractor_unit_assert.svh"
   `TFG_ASSERT_NEXT(a_commit_shows, cmd.commit, rv_ff, "committed result not presented")
   `TFG_ASSERT_NOW(a_invalid_zero, !hv_ff, hsc_ff == 16'd0 && hnd_ff == 17'd0 && htw_ff == 16'sd0, "invalid result carries data")
   `TFG_ASSERT_NEXT(a_valid_held, cmd.commit && touch_ff && cond_ff, hv_ff, "measured gesture not flagged valid")

endmodule
`default_nettype wire

FILE: design/two_finger_gesture_extractor_unit.sv
// Two-finger pan / pinch / rotate extractor.
// Input channel req_*: one event per transfer (req_valid, req_stall). Output
// channel rsp_*: one result per event (rsp_valid, rsp_stall).
// The block works on one event at a time; req_stall is low only while idle.
// A non-touch event, or a touch event that cannot be measured, goes from
// LOAD straight to DONE. A measured event runs two square roots (SQ_X, SQ_Y,
// the ROOT steps, RSQ and RND each), CORDIC_STEPS angle iterations for both
// vectors in parallel, and a 26-step restoring divide for the scale. In both
// cases rsp_valid rises once the result is written to the output register,
// and the next event is taken the cycle after that result is written. The
// sequencer steps the bit-per-cycle root and divide.
// A finished result sits in the output register while the receiver stalls;
// the next event can be worked on meanwhile, but its result waits until the
// output register is taken.
// Reset (synchronous) forgets the previous finger pair and clears the held
// result to all zeros; a non-touch event replays the held result.
`default_nettype none
module two_finger_gesture_extractor_unit #(
   parameter int CORDIC_STEPS = tfg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_is_touch,
   input  wire logic               req_begin_req,
   input  wire logic [3:0]         req_point_count,
   input  wire logic [7:0]         req_id_a,
   input  wire logic               req_ended_a,
   input  wire logic signed [15:0] req_x_a,
   input  wire logic signed [15:0] req_y_a,
   input  wire logic [7:0]         req_id_b,
   input  wire logic               req_ended_b,
   input  wire logic signed [15:0] req_x_b,
   input  wire logic signed [15:0] req_y_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_gesture_valid,
   output logic signed [16:0]      rsp_pan_x,
   output logic signed [16:0]      rsp_pan_y,
   output logic [16:0]             rsp_new_distance,
   output logic [16:0]             rsp_old_distance,
   output logic signed [17:0]      rsp_pinch_pixels,
   output logic signed [15:0]      rsp_mid_x,
   output logic signed [15:0]      rsp_mid_y,
   output logic [15:0]             rsp_scale,
   output logic signed [15:0]      rsp_twist
);
   import tfg_pkg::*;

   tfg_cmd_type cmd;
   tfg_sts_type sts;

   tfg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfg_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_is_touch      (req_is_touch),
      .req_begin_req     (req_begin_req),
      .req_point_count   (req_point_count),
      .req_id_a          (req_id_a),
      .req_ended_a       (req_ended_a),
      .req_x_a           (req_x_a),
      .req_y_a           (req_y_a),
      .req_id_b          (req_id_b),
      .req_ended_b       (req_ended_b),
      .req_x_b           (req_x_b),
      .req_y_b           (req_y_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_gesture_valid (rsp_gesture_valid),
      .rsp_pan_x         (rsp_pan_x),
      .rsp_pan_y         (rsp_pan_y),
      .rsp_new_distance  (rsp_new_distance),
      .rsp_old_distance  (rsp_old_distance),
      .rsp_pinch_pixels  (rsp_pinch_pixels),
      .rsp_mid_x         (rsp_mid_x),
      .rsp_mid_y         (rsp_mid_y),
      .rsp_scale         (rsp_scale),
      .rsp_twist         (rsp_twist)
   );

endmodule
`default_nettype wire

FILE: bench/tb_two_finger_gesture_extractor_unit.sv
`default_nettype none
module tb_two_finger_gesture_extractor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_STEPS   = tfg_pkg::CORDIC_STEPS_DEFAULT;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 120;
   localparam longint HALF_TURN = 3294199;
   localparam longint ARC_STEP[24] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

   typedef struct packed {
      logic              is_touch;
      logic              begin_req;
      logic [3:0]        point_count;
      logic [7:0]        id_a;
      logic              ended_a;
      logic signed [15:0] x_a;
      logic signed [15:0] y_a;
      logic [7:0]        id_b;
      logic              ended_b;
      logic signed [15:0] x_b;
      logic signed [15:0] y_b;
   } touch_event_type;

   typedef struct packed {
      logic              gesture_valid;
      logic signed [16:0] pan_x;
      logic signed [16:0] pan_y;
      logic [16:0]       new_distance;
      logic [16:0]       old_distance;
      logic signed [17:0] pinch_pixels;
      logic signed [15:0] mid_x;
      logic signed [15:0] mid_y;
      logic [15:0]       scale;
      logic signed [15:0] twist;
   } gesture_type;

   typedef struct packed {
      touch_event_type ev;
      logic            typed;
      gesture_type     gesture;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   touch_event_type drv;
   gesture_type got;

   two_finger_gesture_extractor_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_is_touch(drv.is_touch), .req_begin_req(drv.begin_req),
      .req_point_count(drv.point_count),
      .req_id_a(drv.id_a), .req_ended_a(drv.ended_a), .req_x_a(drv.x_a), .req_y_a(drv.y_a),
      .req_id_b(drv.id_b), .req_ended_b(drv.ended_b), .req_x_b(drv.x_b), .req_y_b(drv.y_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_gesture_valid(got.gesture_valid), .rsp_pan_x(got.pan_x), .rsp_pan_y(got.pan_y),
      .rsp_new_distance(got.new_distance), .rsp_old_distance(got.old_distance),
      .rsp_pinch_pixels(got.pinch_pixels), .rsp_mid_x(got.mid_x), .rsp_mid_y(got.mid_y),
      .rsp_scale(got.scale), .rsp_twist(got.twist)
   );

   // tracked finger pair and the held gesture
   logic            pair_present;
   touch_event_type last_pair;
   gesture_type     held_gesture;

   gesture_type pending_gestures[$];
   int  errors = 0;
   int  measured_count = 0;
   int  event_count = 0;
   int  quiet_cycles = 0;
   bit  quiet = 0;
   bit  hold_request = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic longint root_round(longint dx, longint dy);
      longint s, r, b, t;
      s = dx * dx + dy * dy;
      r = 0;
      for (b = 64'd1 << 17; b != 0; b = b >> 1) begin
         t = r + b;
         if (t * t <= s) r = t;
      end
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARC_STEP[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARC_STEP[i];
         end
      end
      return z;
   endfunction

   function automatic gesture_type track_gesture(touch_event_type ev);
      longint nvx, nvy, ovx, ovy, nd, od, q, tw;
      gesture_type g;
      if (!ev.is_touch) return held_gesture;
      g = '0;
      if (ev.begin_req) pair_present = 0;
      if (ev.point_count >= 2 && pair_present && last_pair.id_a == ev.id_a &&
          last_pair.id_b == ev.id_b && !ev.ended_a && !ev.ended_b &&
          !last_pair.ended_a && !last_pair.ended_b) begin
         nvx = longint'(ev.x_b) - ev.x_a;
         nvy = longint'(ev.y_b) - ev.y_a;
         ovx = longint'(last_pair.x_b) - last_pair.x_a;
         ovy = longint'(last_pair.y_b) - last_pair.y_a;
         nd = root_round(nvx, nvy);
         od = root_round(ovx, ovy);
         g.gesture_valid = 1;
         g.pan_x = (longint'(ev.x_a) - last_pair.x_a + ev.x_b - last_pair.x_b) >>> 1;
         g.pan_y = (longint'(ev.y_a) - last_pair.y_a + ev.y_b - last_pair.y_b) >>> 1;
         g.new_distance = nd;
         g.old_distance = od;
         g.pinch_pixels = nd - od;
         g.mid_x = (longint'(ev.x_a) + ev.x_b) >>> 1;
         g.mid_y = (longint'(ev.y_a) + ev.y_b) >>> 1;
         if (od == 0) g.scale = 256;
         else begin
            q = (nd * 256 + od / 2) / od;
            g.scale = (q > 65535) ? 16'hFFFF : q;
         end
         tw = vector_angle(-nvy, -nvx) - vector_angle(-ovy, -ovx);
         tw = (tw + 128) >>> 8;
         if (tw > 32767) tw = 32767;
         if (tw < -32768) tw = -32768;
         g.twist = tw;
      end
      pair_present = (ev.point_count >= 2);
      last_pair = ev;
      held_gesture = g;
      return g;
   endfunction

   task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, e, a);
      end
   endtask

   // result side: compare every transfer with the oldest expectation
   always @(posedge clock) begin
      gesture_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_gestures.size() == 0) begin
            errors++;
            $display("%0t unexpected result, expected none actual %0h", $realtime, got);
         end else begin
            e = pending_gestures.pop_front();
            if (e.gesture_valid) measured_count++;
            check_field("gesture_valid", e.gesture_valid, got.gesture_valid);
            check_field("pan_x", e.pan_x, got.pan_x);
            check_field("pan_y", e.pan_y, got.pan_y);
            check_field("new_distance", e.new_distance, got.new_distance);
            check_field("old_distance", e.old_distance, got.old_distance);
            check_field("pinch_pixels", e.pinch_pixels, got.pinch_pixels);
            check_field("mid_x", e.mid_x, got.mid_x);
            check_field("mid_y", e.mid_y, got.mid_y);
            check_field("scale", e.scale, got.scale);
            check_field("twist", e.twist, got.twist);
         end
      end
   end

   // receiver: random stall, quiet stretch, one long hold-off on request
   initial begin
      int held;
      held = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && held < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            if (held >= HOLD_CYCLES) begin
               hold_request = 0;
               held = 0;
            end
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 10);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_event(touch_event_type ev, logic typed, gesture_type typed_gesture);
      gesture_type g;
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      drv <= ev;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      g = track_gesture(ev);
      pending_gestures.push_back(typed ? typed_gesture : g);
      event_count++;
   endtask

   function automatic touch_event_type finger_pair(logic [7:0] ia, logic [7:0] ib,
         logic first);
      touch_event_type ev;
      ev = '0;
      ev.is_touch = 1;
      ev.begin_req = first;
      ev.point_count = $urandom_range(2, 15);
      ev.id_a = ia;
      ev.id_b = ib;
      ev.x_a = $urandom; ev.y_a = $urandom; ev.x_b = $urandom; ev.y_b = $urandom;
      return ev;
   endfunction

   function automatic touch_event_type nudge(touch_event_type ev);
      ev.begin_req = 0;
      ev.point_count = $urandom_range(2, 15);
      ev.x_a = ev.x_a + $signed($urandom_range(0, 64)) - 32;
      ev.y_a = ev.y_a + $signed($urandom_range(0, 64)) - 32;
      ev.x_b = ev.x_b + $signed($urandom_range(0, 64)) - 32;
      ev.y_b = ev.y_b + $signed($urandom_range(0, 64)) - 32;
      return ev;
   endfunction

   function automatic stim_row_type row(logic t, logic bg, logic [3:0] n, logic [7:0] ia,
         logic ea, int xa, int ya, logic [7:0] ib, logic eb, int xb, int yb, logic typed);
      stim_row_type r;
      r.ev = '{t, bg, n, ia, ea, xa[15:0], ya[15:0], ib, eb, xb[15:0], yb[15:0]};
      r.typed = typed;
      r.gesture = '0;
      return r;
   endfunction

   initial begin
      stim_row_type directed[$];
      touch_event_type ev;
      gesture_type none;
      logic [7:0] ia, ib;
      int run_len;
      bit hold_issued;
      none = '0;
      hold_issued = 0;
      pair_present = 0;
      last_pair = '0;
      held_gesture = '0;
      req_valid = 1'b0;
      drv = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // after reset: non-touch replays zeros; first touch has no previous pair
      directed.push_back(row(0, 0, 2, 1, 0, 100, 100, 2, 0, 200, 200, 1));
      directed.push_back(row(1, 1, 2, 1, 0, 0, 0, 2, 0, 160, 0, 1));
      directed.push_back(row(1, 0, 2, 1, 0, 16, 16, 2, 0, 176, 48, 0));
      directed.push_back(row(0, 1, 15, 9, 1, -1, -1, 9, 1, -1, -1, 0));
      // extremes of the coordinate range
      directed.push_back(row(1, 0, 15, 1, 0, -32768, -32768, 2, 0, 32767, 32767, 0));
      directed.push_back(row(1, 0, 2, 1, 0, 32767, 32767, 2, 0, -32768, -32768, 0));
      directed.push_back(row(1, 0, 2, 1, 0, -32768, 32767, 2, 0, 32767, -32768, 0));
      // zero separation old and new, then growth from zero
      directed.push_back(row(1, 0, 2, 1, 0, 50, 50, 2, 0, 50, 50, 0));
      directed.push_back(row(1, 0, 2, 1, 0, 50, 50, 2, 0, 50, 50, 0));
      directed.push_back(row(1, 0, 2, 1, 0, 50, 50, 2, 0, 32767, 50, 0));
      // vector pointing left along the axis
      directed.push_back(row(1, 0, 2, 1, 0, 100, 0, 2, 0, -100, 0, 0));
      directed.push_back(row(1, 0, 2, 1, 0, 100, 0, 2, 0, 300, 0, 0));
      // lifting finger, then the next event still sees the lift
      directed.push_back(row(1, 0, 2, 1, 1, 0, 0, 2, 0, 10, 10, 1));
      directed.push_back(row(1, 0, 2, 1, 0, 0, 0, 2, 0, 10, 10, 1));
      directed.push_back(row(1, 0, 2, 1, 0, 5, 5, 2, 0, 10, 10, 0));
      directed.push_back(row(1, 0, 2, 1, 0, 5, 5, 2, 1, 10, 10, 1));
      // fewer than two points, and the event after it
      directed.push_back(row(1, 1, 2, 255, 0, 0, 0, 255, 0, 16, 0, 1));
      directed.push_back(row(1, 0, 1, 255, 0, 0, 0, 255, 0, 16, 0, 1));
      directed.push_back(row(1, 0, 2, 255, 0, 0, 0, 255, 0, 16, 0, 1));
      directed.push_back(row(1, 0, 0, 255, 0, 0, 0, 255, 0, 16, 0, 1));
      // finger ids change, then begin on a measured pair
      directed.push_back(row(1, 0, 2, 0, 0, 0, 0, 255, 0, 16, 0, 1));
      directed.push_back(row(1, 0, 2, 0, 0, 0, 0, 254, 0, 16, 0, 1));
      directed.push_back(row(1, 0, 2, 0, 0, 0, 0, 254, 0, 16, 16, 0));
      directed.push_back(row(1, 1, 2, 0, 0, 0, 0, 254, 0, 16, 32, 1));
      directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

      foreach (directed[i]) send_event(directed[i].ev, directed[i].typed, none);

      // sender pause until everything is back
      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; ) begin
         if (n >= 300 && n < 420) quiet = 1;
         else quiet = 0;
         if (n >= 600 && !hold_issued) begin
            hold_request = 1;
            hold_issued = 1;
         end
         if ($urandom_range(0, 99) < 80) begin
            // well-formed gesture: usually a begin, moves, sometimes a lift at the end
            ia = $urandom; ib = $urandom;
            ev = finger_pair(ia, ib, $urandom_range(0, 3) != 0);
            send_event(ev, 0, none);
            n++;
            run_len = $urandom_range(2, 10);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  ev = finger_pair(ia, ib, 0);
               end else if ($urandom_range(0, 19) == 0) begin
                  ev.is_touch = 0;
                  send_event(ev, 0, none);
                  ev.is_touch = 1;
                  ev = nudge(ev);
               end else ev = nudge(ev);
               send_event(ev, 0, none);
               n++;
            end
            if ($urandom_range(0, 1)) begin
               ev.ended_a = $urandom; ev.ended_b = !ev.ended_a || $urandom_range(0, 1);
               send_event(ev, 0, none);
               n++;
            end
         end else begin
            ev = {$urandom, $urandom, $urandom};
            if ($urandom_range(0, 1)) ev.is_touch = 1;
            send_event(ev, 0, none);
            n++;
         end
      end
      quiet = 0;
      req_valid <= 1'b0;
      while (pending_gestures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d events, %0d measured gestures, with stalls on both sides",
               event_count, measured_count);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
